/* hw/rtl/meep_pkg.sv */
// shared widths, codes, reset values and helpers for the escape-time pixel block
package meep_pkg;

  // fixed field widths
  localparam int COL_W      = 9;
  localparam int ROW_W      = 8;
  localparam int CENTRE_W   = 34;
  localparam int STEP_W     = 27;
  localparam int COUNT_W    = 8;
  localparam int RGB_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 34;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_REAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_IMAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 2'd2;

  // register reset values
  localparam logic signed [CENTRE_W-1:0] CENTRE_REAL_RESET = -34'sd201326592;
  localparam logic signed [CENTRE_W-1:0] CENTRE_IMAG_RESET = 34'sd0;
  localparam logic [STEP_W-1:0]          PIXEL_STEP_RESET  = 27'd2516582;

  // parameter defaults
  localparam int DEF_CANVAS_WIDTH    = 320;
  localparam int DEF_CANVAS_HEIGHT   = 240;
  localparam int DEF_FRACTION_BITS   = 28;
  localparam int DEF_ITERATION_LIMIT = 150;
  localparam int QUEUE_DEPTH         = 2;

  // rainbow palette coefficients
  localparam logic [7:0] RED_MUL   = 8'd8;
  localparam logic [7:0] GREEN_MUL = 8'd5;
  localparam logic [7:0] GREEN_OFS = 8'd80;
  localparam logic [7:0] BLUE_MUL  = 8'd11;
  localparam logic [7:0] BLUE_OFS  = 8'd160;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [RGB_W-1:0]   rgb;
  } result_t;

  function automatic int wmax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // signed width of (position - canvas/2)
  function automatic int offset_width(input int canvas, input int in_w);
    return wmax(in_w, $clog2((canvas >> 1) + 1)) + 1;
  endfunction

  // signed width of a mapped point coordinate
  function automatic int point_width(input int cw, input int ch);
    return wmax(wmax(offset_width(cw, COL_W), offset_width(ch, ROW_W)) + STEP_W + 1,
                CENTRE_W) + 1;
  endfunction

  // signed width of the orbit registers
  function automatic int orbit_width(input int cw, input int ch, input int fb);
    return wmax(point_width(cw, ch), fb + 6) + 1;
  endfunction

endpackage

/* hw/rtl/mandelbrot_escape_pixel.sv */
// the iteration engine works on one pixel at a time and takes a new job only when idle;
// each escape iteration runs a multiply state (squares and cross product registered)
// and then an update state, up to the iteration limit
// the front end and both queues overlap mapping and hand-off with the engine's work
// reset (rst_n low, synchronous) empties all queues, idles the engine and loads the
// default centre and step registers
module mandelbrot_escape_pixel import meep_pkg::*; #(
  parameter int CANVAS_WIDTH    = DEF_CANVAS_WIDTH,
  parameter int CANVAS_HEIGHT   = DEF_CANVAS_HEIGHT,
  parameter int FRACTION_BITS   = DEF_FRACTION_BITS,
  parameter int ITERATION_LIMIT = DEF_ITERATION_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel transactions in
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [COL_W-1:0]      in_column,
  input  logic [ROW_W-1:0]      in_row,
  // result transactions out
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [COUNT_W-1:0]    out_iteration_count,
  output logic [RGB_W-1:0]      out_pixel_rgb,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int C_W = point_width(CANVAS_WIDTH, CANVAS_HEIGHT);
  localparam int J_W = 2 * C_W;
  localparam int R_W = $bits(result_t);

  // canvas view registers
  logic signed [CENTRE_W-1:0] centre_real_r;
  logic signed [CENTRE_W-1:0] centre_imag_r;
  logic [STEP_W-1:0]          pixel_step_r;

  // front end to job queue
  logic                  fr_valid;
  logic                  fr_ready;
  logic signed [C_W-1:0] fr_cr;
  logic signed [C_W-1:0] fr_ci;
  logic                  jq_full;

  // job queue to engine
  logic                  jq_empty;
  logic [J_W-1:0]        jq_data;
  logic                  eng_pop;
  logic signed [C_W-1:0] eng_cr;
  logic signed [C_W-1:0] eng_ci;

  // engine to result queue
  logic                  res_valid;
  logic                  rq_full;
  result_t               res_data;
  logic [R_W-1:0]        rq_data;
  result_t               head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_real_r <= CENTRE_REAL_RESET;
      centre_imag_r <= CENTRE_IMAG_RESET;
      pixel_step_r  <= PIXEL_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTRE_REAL: centre_real_r <= $signed(cfg_data);
        CFG_CENTRE_IMAG: centre_imag_r <= $signed(cfg_data);
        CFG_PIXEL_STEP:  pixel_step_r  <= cfg_data[STEP_W-1:0];
        default: begin
          // unused index, write is dropped
        end
      endcase
    end
  end

  // pixel position to complex point, two stages
  meep_front #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_column   (in_column),
    .in_row      (in_row),
    .centre_real (centre_real_r),
    .centre_imag (centre_imag_r),
    .pixel_step  (pixel_step_r),
    .job_valid   (fr_valid),
    .job_ready   (fr_ready),
    .job_cr      (fr_cr),
    .job_ci      (fr_ci)
  );

  assign fr_ready = !jq_full;

  // decouples mapping from the iteration engine
  meep_fifo #(
    .WIDTH (J_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_valid),
    .full    (jq_full),
    .wr_data ({fr_cr, fr_ci}),
    .pop     (eng_pop),
    .empty   (jq_empty),
    .rd_data (jq_data)
  );

  assign eng_cr = $signed(jq_data[J_W-1:C_W]);
  assign eng_ci = $signed(jq_data[C_W-1:0]);

  meep_core #(
    .CANVAS_WIDTH    (CANVAS_WIDTH),
    .CANVAS_HEIGHT   (CANVAS_HEIGHT),
    .FRACTION_BITS   (FRACTION_BITS),
    .ITERATION_LIMIT (ITERATION_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!jq_empty),
    .job_pop   (eng_pop),
    .job_cr    (eng_cr),
    .job_ci    (eng_ci),
    .res_valid (res_valid),
    .res_ready (!rq_full),
    .res_data  (res_data)
  );

  // finished results wait here so the engine can move on
  meep_fifo #(
    .WIDTH (R_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_valid),
    .full    (rq_full),
    .wr_data (res_data),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (rq_data)
  );

  assign head                = result_t'(rq_data);
  assign out_iteration_count = head.count;
  assign out_pixel_rgb       = head.rgb;

endmodule

/* hw/rtl/meep_fifo.sv */
// small first-in first-out queue with registered storage
module meep_fifo import meep_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr_r;
  logic [AW:0]      rd_ptr_r;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign rd_data = mem[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r[AW-1:0]] <= wr_data;
    end
  end

endmodule

/* hw/rtl/meep_front.sv */
// front end: maps a pixel position to its point in the complex plane
module meep_front import meep_pkg::*; #(
  parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_push,
  output logic                                             in_full,
  input  logic [COL_W-1:0]                                 in_column,
  input  logic [ROW_W-1:0]                                 in_row,
  input  logic signed [CENTRE_W-1:0]                       centre_real,
  input  logic signed [CENTRE_W-1:0]                       centre_imag,
  input  logic [STEP_W-1:0]                                pixel_step,
  output logic                                             job_valid,
  input  logic                                             job_ready,
  output logic signed [point_width(CANVAS_WIDTH, CANVAS_HEIGHT)-1:0] job_cr,
  output logic signed [point_width(CANVAS_WIDTH, CANVAS_HEIGHT)-1:0] job_ci
);

  localparam int OX_W = offset_width(CANVAS_WIDTH, COL_W);
  localparam int OY_W = offset_width(CANVAS_HEIGHT, ROW_W);
  localparam int PX_W = OX_W + STEP_W + 1;
  localparam int PY_W = OY_W + STEP_W + 1;
  localparam int C_W  = point_width(CANVAS_WIDTH, CANVAS_HEIGHT);
  localparam logic signed [OX_W-1:0] HALF_X = OX_W'(CANVAS_WIDTH / 2);
  localparam logic signed [OY_W-1:0] HALF_Y = OY_W'(CANVAS_HEIGHT / 2);

  logic signed [OX_W-1:0]   off_x;
  logic signed [OY_W-1:0]   off_y;
  logic signed [STEP_W:0]   step_s;
  logic signed [PX_W-1:0]   prod_x;
  logic signed [PY_W-1:0]   prod_y;
  logic signed [PX_W-1:0]   px_r;
  logic signed [PY_W-1:0]   py_r;
  logic                     s1_v_r;
  logic signed [C_W-1:0]    cr_r;
  logic signed [C_W-1:0]    ci_r;
  logic                     s2_v_r;
  logic                     s2_free;
  logic                     s1_move;
  logic                     in_take;

  assign off_x  = $signed(OX_W'(in_column)) - HALF_X;
  assign off_y  = $signed(OY_W'(in_row)) - HALF_Y;
  assign step_s = $signed({1'b0, pixel_step});
  assign prod_x = off_x * step_s;
  assign prod_y = off_y * step_s;

  assign s2_free = !s2_v_r || job_ready;
  assign s1_move = s1_v_r && s2_free;
  assign in_full = s1_v_r && !s2_free;
  assign in_take = in_push && !in_full;

  assign job_valid = s2_v_r;
  assign job_cr    = cr_r;
  assign job_ci    = ci_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        s2_v_r <= 1'b1;
      end else if (job_ready) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      px_r <= prod_x;
      py_r <= prod_y;
    end
    if (s1_move) begin
      cr_r <= C_W'(centre_real) + C_W'(px_r);
      ci_r <= C_W'(centre_imag) + C_W'(py_r);
    end
  end

endmodule

/* hw/rtl/meep_core.sv */
// back end: escape-time iteration engine and palette lookup
module meep_core import meep_pkg::*; #(
  parameter int CANVAS_WIDTH    = DEF_CANVAS_WIDTH,
  parameter int CANVAS_HEIGHT   = DEF_CANVAS_HEIGHT,
  parameter int FRACTION_BITS   = DEF_FRACTION_BITS,
  parameter int ITERATION_LIMIT = DEF_ITERATION_LIMIT
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             job_valid,
  output logic                                             job_pop,
  input  logic signed [point_width(CANVAS_WIDTH, CANVAS_HEIGHT)-1:0] job_cr,
  input  logic signed [point_width(CANVAS_WIDTH, CANVAS_HEIGHT)-1:0] job_ci,
  output logic                                             res_valid,
  input  logic                                             res_ready,
  output result_t                                          res_data
);

  localparam int C_W   = point_width(CANVAS_WIDTH, CANVAS_HEIGHT);
  localparam int ZW    = orbit_width(CANVAS_WIDTH, CANVAS_HEIGHT, FRACTION_BITS);
  localparam int T_W   = FRACTION_BITS + 3;
  localparam int SQ_W  = 2 * T_W;
  localparam int CNT_W = $clog2(ITERATION_LIMIT + 1);
  localparam logic signed [ZW-1:0] BIG     = ZW'(1) << (FRACTION_BITS + 2);
  localparam logic signed [ZW-1:0] NEG_BIG = -BIG;
  localparam logic signed [ZW-1:0] BOUND   = ZW'(4) << FRACTION_BITS;
  localparam logic [CNT_W-1:0]     LIMIT   = CNT_W'(ITERATION_LIMIT);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_UPD, ST_DONE} state_t;

  state_t                 state_r;
  logic signed [C_W-1:0]  cr_r;
  logic signed [C_W-1:0]  ci_r;
  logic signed [ZW-1:0]   zr_r;
  logic signed [ZW-1:0]   zi_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [SQ_W-1:0] sq_rr_r;
  logic signed [SQ_W-1:0] sq_ii_r;
  logic signed [SQ_W-1:0] cross_r;
  logic                   big_r;
  result_t                res_r;

  logic signed [T_W-1:0]  zr_t;
  logic signed [T_W-1:0]  zi_t;
  logic signed [SQ_W-1:0] sq_rr;
  logic signed [SQ_W-1:0] sq_ii;
  logic signed [SQ_W-1:0] cross_prod;
  logic                   big;
  logic signed [ZW-1:0]   zr2;
  logic signed [ZW-1:0]   zi2;
  logic signed [ZW-1:0]   mag;
  logic signed [ZW-1:0]   zr_nxt;
  logic signed [ZW-1:0]   zi_nxt;
  logic                   escape;
  logic [CNT_W-1:0]       cnt_inc;

  function automatic result_t colour(input logic [CNT_W-1:0] n);
    result_t    res;
    logic [7:0] n8;
    n8        = 8'(n);
    res.count = COUNT_W'(n);
    if (n >= LIMIT) begin
      res.rgb = '0;
    end else begin
      res.rgb = {8'(n8 * RED_MUL), 8'(n8 * GREEN_MUL + GREEN_OFS),
                 8'(n8 * BLUE_MUL + BLUE_OFS)};
    end
    return res;
  endfunction

  // operands are only meaningful when the orbit is below the big bound
  assign zr_t       = zr_r[T_W-1:0];
  assign zi_t       = zi_r[T_W-1:0];
  assign sq_rr      = zr_t * zr_t;
  assign sq_ii      = zi_t * zi_t;
  assign cross_prod = zr_t * zi_t;
  assign big   = (zr_r >= BIG) || (zr_r <= NEG_BIG) || (zi_r >= BIG) || (zi_r <= NEG_BIG);

  assign zr2     = ZW'(sq_rr_r >>> FRACTION_BITS);
  assign zi2     = ZW'(sq_ii_r >>> FRACTION_BITS);
  assign mag     = zr2 + zi2;
  assign escape  = big_r || (mag > BOUND);
  assign zr_nxt  = zr2 - zi2 + ZW'(cr_r);
  assign zi_nxt  = ZW'(cross_r >>> (FRACTION_BITS - 1)) + ZW'(ci_r);
  assign cnt_inc = cnt_r + 1'b1;

  assign job_pop   = (state_r == ST_IDLE) && job_valid;
  assign res_valid = (state_r == ST_DONE);
  assign res_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            cr_r    <= job_cr;
            ci_r    <= job_ci;
            zr_r    <= '0;
            zi_r    <= '0;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          sq_rr_r <= sq_rr;
          sq_ii_r <= sq_ii;
          cross_r <= cross_prod;
          big_r   <= big;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (escape) begin
            res_r   <= colour(cnt_r);
            state_r <= ST_DONE;
          end else if (cnt_inc == LIMIT) begin
            res_r   <= colour(LIMIT);
            state_r <= ST_DONE;
          end else begin
            zr_r    <= zr_nxt;
            zi_r    <= zi_nxt;
            cnt_r   <= cnt_inc;
            state_r <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
